// ===== hw/rtl/rmt_pkg.sv =====
// Shared constants for the running median tracker.
`default_nettype none
package rmt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 32;

endpackage
`default_nettype wire

// ===== hw/rtl/rmt_cell.sv =====
// One slot of the sorted sample chain, with its insert decision and median taps.
`default_nettype none
module rmt_cell #(
	parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W = 7,
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  wire logic                   clk,
	input  wire logic                   ins,
	input  wire logic [SAMPLE_BITS-1:0] new_val,
	input  wire logic [CNT_W-1:0]       fill,
	input  wire logic [SAMPLE_BITS-1:0] left_val,
	input  wire logic                   left_shift,
	input  wire logic [IDX_W-1:0]       lo_idx,
	input  wire logic [IDX_W-1:0]       hi_idx,
	output logic      [SAMPLE_BITS-1:0] val,
	output logic                        shift,
	output logic      [SAMPLE_BITS-1:0] tap_lo,
	output logic      [SAMPLE_BITS-1:0] tap_hi
);

	logic [SAMPLE_BITS-1:0] val_q;

	// An empty slot or a larger value moves up to make room.
	assign shift = (CNT_W'(INDEX) >= fill) || (val_q > new_val);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ins && shift) begin
			val_q <= left_shift ? left_val : new_val;
		end
	end

	assign tap_lo = (IDX_W'(INDEX) == lo_idx) ? val_q : '0;
	assign tap_hi = (IDX_W'(INDEX) == hi_idx) ? val_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/running_median_tracker.sv =====
// Top level of the running median tracker: cell chain, median select and output register.
// The stored samples are kept in a row of CAPACITY sorted cells; an accepted beat is
// inserted by all cells comparing against it at once and shifting larger entries up one
// slot. The block takes one beat per cycle while its output is not stalled. A beat goes
// through the insert into the row, the pick of the two middle cells out of the row into
// the select registers, and their average into the registered output. A beat with
// start_new set (tuser) empties the row before its sample goes in; with the row full the
// sample is dropped and overflow is set. The output register stalls the whole pipe while
// it holds a beat and m_tready is low, so s_tready follows m_tready once the output is occupied.
`default_nettype none
module running_median_tracker #(
	parameter int CAPACITY = rmt_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + CNT_W + 2 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // sample
	input  wire logic             s_tuser,  // start_new
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata   // median_floor, median_half, stored_count, overflow
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic                   advance;
	logic                   accept;
	logic [SAMPLE_BITS-1:0] new_u;
	logic [CNT_W-1:0]       fill;
	logic                   full;
	logic                   ins;
	logic [CNT_W-1:0]       count_q;

	logic                   valid_s1;
	logic [CNT_W-1:0]       count_s1;
	logic                   ovf_s1;
	logic [IDX_W-1:0]       lo_idx;
	logic [IDX_W-1:0]       hi_idx;

	logic                   valid_s2;
	logic [CNT_W-1:0]       count_s2;
	logic                   ovf_s2;
	logic [SAMPLE_BITS-1:0] lo_s2;
	logic [SAMPLE_BITS-1:0] hi_s2;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] floor_q;
	logic                   half_q;
	logic [CNT_W-1:0]       count_out_q;
	logic                   ovf_q;

	logic [SAMPLE_BITS-1:0] cell_val [CAPACITY];
	logic                   cell_shift [CAPACITY];
	logic [SAMPLE_BITS-1:0] tap_lo [CAPACITY];
	logic [SAMPLE_BITS-1:0] tap_hi [CAPACITY];
	logic [SAMPLE_BITS-1:0] lo_sel;
	logic [SAMPLE_BITS-1:0] hi_sel;
	logic [SAMPLE_BITS:0]   sum;
	logic [CNT_W-1:0]       count_m1;

	assign advance = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign accept = s_tvalid && advance;

	// Offset binary: an unsigned compare then orders signed samples.
	assign new_u = s_tdata[SAMPLE_BITS-1:0] ^ SIGN;
	assign fill = s_tuser ? '0 : count_q;
	assign full = (fill == CNT_W'(CAPACITY));
	assign ins = accept && !full;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] left_val;
		logic                   left_shift;
		if (i == 0) begin : g_first
			assign left_val = '0;
			assign left_shift = 1'b0;
		end else begin : g_rest
			assign left_val = cell_val[i-1];
			assign left_shift = cell_shift[i-1];
		end
		rmt_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.CNT_W(CNT_W),
			.IDX_W(IDX_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ins(ins),
			.new_val(new_u),
			.fill(fill),
			.left_val(left_val),
			.left_shift(left_shift),
			.lo_idx(lo_idx),
			.hi_idx(hi_idx),
			.val(cell_val[i]),
			.shift(cell_shift[i]),
			.tap_lo(tap_lo[i]),
			.tap_hi(tap_hi[i])
		);
	end

	// Lower and upper middle; they coincide for an odd count.
	assign count_m1 = count_s1 - CNT_W'(1);
	assign lo_idx = IDX_W'(count_m1 >> 1);
	assign hi_idx = IDX_W'(count_s1 >> 1);

	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			lo_sel = lo_sel | tap_lo[i];
			hi_sel = hi_sel | tap_hi[i];
		end
	end

	assign sum = {1'b0, lo_s2} + {1'b0, hi_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (accept) begin
				count_q <= fill + CNT_W'(ins);
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_s1 <= fill + CNT_W'(ins);
			ovf_s1 <= full;
			count_s2 <= count_s1;
			ovf_s2 <= ovf_s1;
			lo_s2 <= lo_sel;
			hi_s2 <= hi_sel;
			floor_q <= sum[SAMPLE_BITS:1] ^ SIGN;
			half_q <= sum[0];
			count_out_q <= count_s2;
			ovf_q <= ovf_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_W'({ovf_q, count_out_q, half_q, floor_q});

endmodule
`default_nettype wire

// ===== hw/rtl/rmt_checker.sv =====
// Port-level checks for the running median tracker and their bind.
`default_nettype none
module rmt_checker #(
	parameter int CAPACITY = rmt_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int OUT_W = ((SAMPLE_BITS + CNT_W + 2 + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	logic [CNT_W-1:0] cnt;
	logic             half;
	logic             ovf;

	assign cnt = m_tdata[SAMPLE_BITS+CNT_W:SAMPLE_BITS+1];
	assign half = m_tdata[SAMPLE_BITS];
	assign ovf = m_tdata[SAMPLE_BITS+CNT_W+1];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result beat waiting");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt != '0) && (cnt <= CNT_W'(CAPACITY)))
		else $error("stored count out of range");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ovf |-> cnt == CNT_W'(CAPACITY))
		else $error("overflow with room left in the store");

	a_odd_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt[0] |-> !half)
		else $error("half flag set for an odd count");

endmodule

bind running_median_tracker rmt_checker #(
	.CAPACITY(CAPACITY),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_rmt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for running_median_tracker with a sorted-list median predictor.
`timescale 1ns / 100ps

module tb;

	localparam int SAMPLE_W = rmt_pkg::SAMPLE_BITS_DEF;
	localparam int CNT_W = $clog2(rmt_pkg::CAPACITY_DEF + 1);
	localparam int IN_W = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_W = ((SAMPLE_W + CNT_W + 2 + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		sample_t          floor_val;
		logic             half;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} median_t;

	typedef enum int {
		VAL_FULL,
		VAL_NARROW,
		VAL_EXTREME,
		VAL_MIXED
	} value_kind_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;  // sample
	logic             s_tuser;  // start_new
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;  // median_floor, median_half, stored_count, overflow

	sample_t held_samples[$];
	median_t pending_medians[$];
	int      error_count = 0;
	int      cycle_count = 0;
	int      hold_cycles = 0;
	int      stall_left = 0;
	bit      tx_idle_en = 0;
	bit      rx_idle_en = 0;

	running_median_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result receiver: random short stalls, plus one long hold requested by a test.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles--;
		end else if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			m_tready = 1'b0;
			stall_left = $urandom_range(1, 4) - 1;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		median_t got;
		median_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.floor_val = m_tdata[SAMPLE_W-1:0];
			got.half = m_tdata[SAMPLE_W];
			got.count = m_tdata[SAMPLE_W+CNT_W:SAMPLE_W+1];
			got.ovf = m_tdata[SAMPLE_W+CNT_W+1];
			if (pending_medians.size() == 0) begin
				$error("result beat with no expectation waiting");
				error_count++;
			end else begin
				want = pending_medians.pop_front();
				if (got.floor_val !== want.floor_val) begin
					$error("median_floor: expected %0d, actual %0d", want.floor_val, got.floor_val);
					error_count++;
				end
				if (got.half !== want.half) begin
					$error("median_half: expected %0d, actual %0d", want.half, got.half);
					error_count++;
				end
				if (got.count !== want.count) begin
					$error("stored_count: expected %0d, actual %0d", want.count, got.count);
					error_count++;
				end
				if (got.ovf !== want.ovf) begin
					$error("overflow: expected %0d, actual %0d", want.ovf, got.ovf);
					error_count++;
				end
			end
		end
	end

	task automatic predict_median(input sample_t value, input bit start);
		median_t          res;
		int               pos;
		int               n;
		logic signed [SAMPLE_W:0] pair_sum;
		if (start)
			held_samples.delete();
		res.ovf = 1'b0;
		if (held_samples.size() >= rmt_pkg::CAPACITY_DEF) begin
			res.ovf = 1'b1;
		end else begin
			pos = held_samples.size();
			while (pos > 0 && held_samples[pos-1] > value)
				pos--;
			held_samples.insert(pos, value);
		end
		n = held_samples.size();
		if (n % 2 == 1) begin
			res.floor_val = held_samples[(n - 1) / 2];
			res.half = 1'b0;
		end else begin
			pair_sum = $signed({held_samples[n/2-1][SAMPLE_W-1], held_samples[n/2-1]})
				+ $signed({held_samples[n/2][SAMPLE_W-1], held_samples[n/2]});
			res.floor_val = pair_sum[SAMPLE_W:1];
			res.half = pair_sum[0];
		end
		res.count = CNT_W'(n);
		pending_medians.push_back(res);
	endtask

	task automatic send_sample(input sample_t value, input bit start);
		int gap;
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = IN_W'(value);
		s_tuser = start;
		do
			@(posedge clk);
		while (!s_tready);
		predict_median(value, start);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_medians.size() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t pick_sample(input value_kind_t kind);
		value_kind_t k;
		k = kind;
		if (k == VAL_MIXED)
			k = value_kind_t'($urandom_range(0, 2));
		case (k)
			VAL_NARROW: return sample_t'($signed($urandom_range(0, 16)) - 8);
			VAL_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});
					1: return sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
					2: return sample_t'({1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1});
					3: return sample_t'({1'b0, {(SAMPLE_W-2){1'b1}}, 1'b0});
					4: return '0;
					default: return '1;
				endcase
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic test_directed_extremes();
		sample_t s_max;
		sample_t s_min;
		s_max = {1'b0, {(SAMPLE_W-1){1'b1}}};
		s_min = {1'b1, {(SAMPLE_W-1){1'b0}}};
		send_sample(s_max, 1'b1);
		send_sample(s_min, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(s_min, 1'b1);
		send_sample(s_min, 1'b0);
		send_sample(s_max, 1'b1);
		send_sample(s_max, 1'b0);
		send_sample(-3, 1'b1);
		send_sample(-4, 1'b0);
		send_sample(3, 1'b1);
		send_sample(4, 1'b0);
		send_sample(sample_t'(32'h5555_5555), 1'b1);
		send_sample(sample_t'(32'hAAAA_AAAA), 1'b0);
	endtask

	task automatic test_full_store();
		send_sample(pick_sample(VAL_FULL), 1'b1);
		repeat (rmt_pkg::CAPACITY_DEF - 1) send_sample(pick_sample(VAL_MIXED), 1'b0);
		send_sample(pick_sample(VAL_EXTREME), 1'b0);
		send_sample(pick_sample(VAL_FULL), 1'b0);
		send_sample(0, 1'b0);
		send_sample(pick_sample(VAL_FULL), 1'b1);
		send_sample(pick_sample(VAL_FULL), 1'b0);
	endtask

	task automatic test_random_runs(input int item_total);
		int          sent;
		int          run_len;
		int          i;
		int          sel;
		value_kind_t kind;
		bit          start;
		sent = 0;
		while (sent < item_total) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				run_len = $urandom_range(1, 40);
			else if (sel < 9)
				run_len = $urandom_range(41, 70);
			else
				run_len = $urandom_range(64, 100);
			kind = value_kind_t'($urandom_range(0, 3));
			for (i = 0; i < run_len && sent < item_total; i++) begin
				start = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
				send_sample(pick_sample(kind), start);
				sent++;
			end
		end
	endtask

	task automatic test_output_backpressure();
		hold_cycles = 200;
		test_random_runs(150);
	endtask

	task automatic test_sender_pause();
		stop_sending();
		drain_results();
		repeat ($urandom_range(1, 6)) @(posedge clk);
		test_random_runs(60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_directed_extremes();
		test_full_store();
		test_random_runs(800);
		test_output_backpressure();
		test_sender_pause();
		test_random_runs(150);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_runs(200);

		stop_sending();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_cell.sv
hw/rtl/running_median_tracker.sv
hw/rtl/rmt_checker.sv
tb/tb.sv
